// ===== sv/sorted_priority_queue_defines.svh =====
// Assertion macros used by the queue datapath.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PEEK   = 2'd1,
      OP_POP    = 2'd2,
      OP_CLEAR  = 2'd3
   } req_op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } rsp_status_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_HOLD
   } ctrl_state_type;

   typedef struct packed {
      logic exec;
      logic drain;
   } dp_cmd_type;

endpackage

// ===== sv/spq_if.sv =====
interface spq_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          req_type;
   logic signed [spq_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface spq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spq_pkg::VALUE_W-1:0]  head_value;
   logic [1:0]                          status;

   modport source (output valid, output head_value, output status, input ready);
   modport sink   (input valid, input head_value, input status, output ready);
endinterface

// ===== sv/spq_ctrl.sv =====
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output spq_pkg::dp_cmd_type cmd
);
   import spq_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign req_ready = (state_ff == CTRL_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               state_in = CTRL_HOLD;
            end
         end
         CTRL_HOLD: begin
            if (rsp_ready && !accept) begin
               state_in = CTRL_IDLE;
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   always_comb begin
      cmd.exec  = accept;
      cmd.drain = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         CTRL_IDLE: begin
            rsp_valid = 1'b0;
         end
         CTRL_HOLD: begin
            rsp_valid = 1'b1;
            cmd.drain = rsp_ready;
         end
         default: rsp_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/spq_dp.sv =====
`include "sorted_priority_queue_defines.svh"

module spq_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::dp_cmd_type                cmd,
   input  logic [1:0]                         req_type,
   input  logic signed [spq_pkg::VALUE_W-1:0] value,
   output logic signed [spq_pkg::VALUE_W-1:0] head_value,
   output logic [1:0]                         status
);
   import spq_pkg::*;

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [VALUE_W-1:0] head_ff, head_in;
   rsp_status_type            status_ff, status_in;
   logic [DEPTH-1:0]          go;
   logic                      full, empty;
   req_op_type                op;

   assign op    = req_op_type'(req_type);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // go[i]: cell i lies at or after the insert slot
   always_comb begin
      logic prev;
      logic hit;
      prev = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0) begin
            hit = (value >= entries_ff[0]);
         end else begin
            hit = (value > entries_ff[i]);
         end
         go[i] = prev || hit || (CNT_W'(i) >= count_ff);
         prev  = go[i];
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      count_in  = count_ff;
      head_in   = '0;
      status_in = STAT_OK;
      unique case (op)
         OP_INSERT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               for (int i = 0; i < DEPTH; i++) begin
                  if (i == 0) begin
                     if (go[0]) begin
                        entries_in[0] = value;
                     end
                  end else if (go[i - 1]) begin
                     entries_in[i] = entries_ff[i - 1];
                  end else if (go[i]) begin
                     entries_in[i] = value;
                  end
               end
            end
         end
         OP_PEEK: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               head_in = entries_ff[0];
            end
         end
         OP_POP: begin
            if (empty) begin
               status_in = STAT_EMPTY;
            end else begin
               head_in  = entries_ff[0];
               count_in = count_ff - 1'b1;
               for (int i = 0; i < DEPTH - 1; i++) begin
                  entries_in[i] = entries_ff[i + 1];
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         entries_ff <= entries_in;
         head_ff    <= head_in;
         status_ff  <= status_in;
      end
   end

   assign head_value = head_ff;
   assign status     = status_ff;

   `SPQ_ASSERT_NEXT(a_full_drop, clock, reset, cmd.exec && op == OP_INSERT && full,
      count_ff == $past(count_ff) && status == STAT_FULL, "insert into full queue kept")
   `SPQ_ASSERT_NEXT(a_pop_head, clock, reset, cmd.exec && op == OP_POP && !empty,
      head_value == $past(entries_ff[0]) && count_ff == $past(count_ff) - 1'b1,
      "pop lost head or count")
   `SPQ_ASSERT_NEXT(a_clear, clock, reset, cmd.exec && op == OP_CLEAR,
      count_ff == '0 && status == STAT_OK, "clear left entries")
   `SPQ_ASSERT_NOW(a_order, clock, reset, count_ff >= CNT_W'(2),
      entries_ff[0] >= entries_ff[1], "head out of order")
   `SPQ_ASSERT_NOW(a_bound, clock, reset, cmd.drain || cmd.exec,
      count_ff <= CNT_W'(DEPTH), "count past depth")

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Channel | Dir | Word
// req_if  | in  | req_type (0 insert, 1 peek, 2 pop, 3 clear), value (signed 32)
// rsp_if  | out | head_value (signed 32), status (0 ok, 1 empty, 2 full)
//
// Every request is executed in the cycle it is accepted: on an insert all cells
// compare against the new value at once and shift in one step, so one word per
// cycle while rsp_if.ready is high. The result sits in an output register; a new
// request is taken while it waits only if rsp_if.ready is high in that cycle.
// Reset (synchronous) empties the queue and clears the pending result.
module sorted_priority_queue (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);
   import spq_pkg::*;

   dp_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   spq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_type   (req_if.req_type),
      .value      (req_if.value),
      .head_value (rsp_if.head_value),
      .status     (rsp_if.status)
   );

endmodule

// ===== bench/sorted_priority_queue_tb.sv =====
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
   localparam int RANDOM_WORDS = 900;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PLAN_ROWS    = 20;

   typedef struct packed {
      req_op_type                op;
      logic signed [VALUE_W-1:0] value;
      logic [4:0]                reps;
      logic                      typed;
      logic signed [VALUE_W-1:0] head;
      rsp_status_type            status;
   } plan_row_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] head;
      rsp_status_type            status;
   } rsp_word_type;

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic signed [VALUE_W-1:0] shadow_vals [DEPTH];
   int                        shadow_count;
   rsp_word_type              rsp_due [$];
   bit                        steady;
   int                        errors;
   int                        words_checked;
   int                        op_seen [4];
   int                        full_drops;
   int                        empty_reads;
   int                        quiet_cycles;

   plan_row_type plan [PLAN_ROWS] = '{
      '{OP_PEEK,   32'sd0,           5'd1,  1'b1, 32'sd0, STAT_EMPTY},
      '{OP_POP,    32'sd0,           5'd1,  1'b1, 32'sd0, STAT_EMPTY},
      '{OP_CLEAR,  32'sd0,           5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, 32'sd0,           5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, VMAX,             5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, VMIN,             5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, VMAX,             5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, -32'sd1,          5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, 32'sd0,           5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_PEEK,   32'sd0,           5'd1,  1'b1, VMAX,   STAT_OK},
      '{OP_POP,    32'sd0,           5'd1,  1'b1, VMAX,   STAT_OK},
      '{OP_POP,    32'sd0,           5'd1,  1'b1, VMAX,   STAT_OK},
      '{OP_POP,    32'sd0,           5'd1,  1'b0, 32'sd0, STAT_OK},
      '{OP_INSERT, 32'sh5A5A_A5A5,   5'd13, 1'b1, 32'sd0, STAT_OK},
      '{OP_INSERT, -32'sd7,          5'd1,  1'b1, 32'sd0, STAT_FULL},
      '{OP_POP,    32'sd0,           5'd1,  1'b0, 32'sd0, STAT_OK},
      '{OP_CLEAR,  32'sd0,           5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_PEEK,   32'sd0,           5'd1,  1'b1, 32'sd0, STAT_EMPTY},
      '{OP_INSERT, VMIN,             5'd1,  1'b1, 32'sd0, STAT_OK},
      '{OP_POP,    32'sd0,           5'd1,  1'b0, 32'sd0, STAT_OK}
   };

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic predict_queue_op(input req_op_type op, input logic signed [VALUE_W-1:0] v,
                                   output rsp_word_type word);
      int  slot;
      bit  found;
      word.head   = '0;
      word.status = STAT_OK;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= DEPTH) begin
               word.status = STAT_FULL;
            end else begin
               slot  = shadow_count;
               found = 1'b0;
               if (shadow_count == 0 || v >= shadow_vals[0]) begin
                  slot  = 0;
                  found = 1'b1;
               end
               for (int i = 1; i < shadow_count && !found; i++) begin
                  if (v > shadow_vals[i]) begin
                     slot  = i;
                     found = 1'b1;
                  end
               end
               for (int i = shadow_count; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
               shadow_vals[slot] = v;
               shadow_count++;
            end
         end
         OP_PEEK: begin
            if (shadow_count == 0) word.status = STAT_EMPTY;
            else                   word.head   = shadow_vals[0];
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               word.status = STAT_EMPTY;
            end else begin
               word.head = shadow_vals[0];
               for (int i = 1; i < shadow_count; i++) shadow_vals[i-1] = shadow_vals[i];
               shadow_count--;
            end
         end
         default: shadow_count = 0;
      endcase
   endtask

   task automatic flag_mismatch(input string what, input logic signed [VALUE_W-1:0] got,
                                input logic signed [VALUE_W-1:0] want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Call at a rising edge; returns at the edge that accepts the word.
   task automatic send_word(input req_op_type op, input logic signed [VALUE_W-1:0] v,
                            input bit typed, input logic signed [VALUE_W-1:0] t_head,
                            input rsp_status_type t_status);
      rsp_word_type word;
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.req_type <= op;
      req_if.value    <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_queue_op(op, v, word);
      if (word.status == STAT_FULL)  full_drops++;
      if (word.status == STAT_EMPTY) empty_reads++;
      op_seen[op]++;
      if (typed) begin
         word.head   = t_head;
         word.status = t_status;
      end
      rsp_due.push_back(word);
   endtask

   task automatic send_op(input req_op_type op, input logic signed [VALUE_W-1:0] v);
      send_word(op, v, 1'b0, '0, STAT_OK);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0:       return VMAX;
         1:       return VMIN;
         2, 3:    return int'($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_op_type draw_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 42) return OP_INSERT;
      if (r < 62) return OP_PEEK;
      if (r < 96) return OP_POP;
      return OP_CLEAR;
   endfunction

   initial begin
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 34);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rsp_due.size() == 0) begin
            flag_mismatch("unexpected result word, head", rsp_if.head_value, '0);
         end else begin
            want = rsp_due.pop_front();
            words_checked++;
            if (rsp_if.head_value !== want.head)
               flag_mismatch("head_value", rsp_if.head_value, want.head);
            if (rsp_if.status !== want.status)
               flag_mismatch("status", VALUE_W'(rsp_if.status), VALUE_W'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("** sorted_priority_queue: FAILED **");
      $finish;
   end

   initial begin
      int  sent;
      int  kind;
      int  burst;
      bit  paused;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = OP_INSERT;
      req_if.value    = '0;
      steady          = 1'b0;
      shadow_count    = 0;
      errors          = 0;
      words_checked   = 0;
      full_drops      = 0;
      empty_reads     = 0;
      quiet_cycles    = 0;
      paused          = 1'b0;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++)
            send_word(plan[r].op, plan[r].value, plan[r].typed, plan[r].head, plan[r].status);
      end

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         steady = (sent >= 300 && sent < 450);
         if ((!paused && sent >= 450) || $urandom_range(0, 99) < 3) begin
            wait_drained();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            while (shadow_count < DEPTH) begin
               send_op(OP_INSERT, draw_value());
               sent++;
            end
            burst = $urandom_range(1, 3);
            repeat (burst) begin
               send_op(OP_INSERT, draw_value());
               sent++;
            end
         end else if (kind < 55) begin
            while (shadow_count > 0) begin
               send_op(($urandom_range(0, 4) == 0) ? OP_PEEK : OP_POP, draw_value());
               sent++;
            end
            burst = $urandom_range(1, 2);
            repeat (burst) begin
               send_op(($urandom_range(0, 1) == 0) ? OP_PEEK : OP_POP, draw_value());
               sent++;
            end
         end else if (kind < 95) begin
            burst = $urandom_range(8, 20);
            repeat (burst) begin
               send_op(draw_op(), draw_value());
               sent++;
            end
         end else begin
            send_op(OP_CLEAR, draw_value());
            send_op(OP_PEEK, draw_value());
            sent += 2;
         end
      end

      wait_drained();
      repeat (4) @(posedge clock);
      $display("run covered %0d inserts, %0d peeks, %0d pops, %0d clears; %0d words checked",
               op_seen[OP_INSERT], op_seen[OP_PEEK], op_seen[OP_POP], op_seen[OP_CLEAR],
               words_checked);
      $display("full drops %0d, empty reads %0d, mismatches %0d",
               full_drops, empty_reads, errors);
      if (errors == 0 && rsp_due.size() == 0)
         $display("** sorted_priority_queue: PASSED **");
      else
         $display("** sorted_priority_queue: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_if.sv
sv/spq_ctrl.sv
sv/spq_dp.sv
sv/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
